>>> design/oat_pkg.sv
package oat_pkg;

    localparam logic [3:0] CMD_READ       = 4'd0;
    localparam logic [3:0] CMD_WRITE      = 4'd1;
    localparam logic [3:0] CMD_INSERT     = 4'd2;
    localparam logic [3:0] CMD_PUSH_BACK  = 4'd3;
    localparam logic [3:0] CMD_PUSH_FRONT = 4'd4;
    localparam logic [3:0] CMD_ERASE      = 4'd5;
    localparam logic [3:0] CMD_POP_BACK   = 4'd6;
    localparam logic [3:0] CMD_FIND       = 4'd7;
    localparam logic [3:0] CMD_CLEAR      = 4'd8;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [3:0]         command;
        logic [6:0]         index;
        logic [6:0]         length;
        logic signed [31:0] value;
    } oat_in_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               found;
        logic [5:0]         found_index;
        logic [6:0]         count;
        logic [1:0]         status;
    } oat_out_t;

    typedef enum logic [2:0] {
        WALK_NONE,
        WALK_READ,
        WALK_INSERT,
        WALK_ERASE,
        WALK_FIND
    } oat_walk_t;

    typedef struct packed {
        oat_walk_t  walk;
        logic       do_write;
        logic [1:0] status;
    } oat_plan_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_INSERT,
        ST_ERASE,
        ST_FIND,
        ST_FINISH
    } oat_state_t;

endpackage

>>> design/oat_plan.sv
module oat_plan #(
    parameter int CAPACITY = 64,
    parameter int CW       = 7
) (
    input  oat_pkg::oat_in_t   cmd,
    input  logic [CW-1:0]      count,
    output oat_pkg::oat_plan_t plan,
    output logic [CW-1:0]      new_count,
    output logic [CW-1:0]      start,
    output logic [CW-1:0]      stop,
    output logic [CW-1:0]      offset
);
    import oat_pkg::*;

    localparam int XW = CW + 8;

    logic [XW-1:0] ix;
    logic [XW-1:0] cx;
    logic [XW-1:0] lx;
    logic [XW-1:0] cap_x;
    logic [XW-1:0] at_x;
    logic [XW-1:0] span_x;
    logic [XW-1:0] lenc_x;

    assign ix     = XW'(cmd.index);
    assign cx     = XW'(count);
    assign lx     = XW'(cmd.length);
    assign cap_x  = XW'(CAPACITY);
    assign span_x = cx - ix;
    assign lenc_x = (lx > span_x) ? span_x : lx;

    always_comb
    begin
        plan      = '{walk: WALK_NONE, do_write: 1'b0, status: STAT_OK};
        new_count = count;
        start     = CW'(ix);
        stop      = count;
        offset    = '0;
        at_x      = ix;
        unique case (cmd.command)
            CMD_READ:
            begin
                if (ix < cx)
                    plan.walk = WALK_READ;
                else
                    plan.status = STAT_RANGE;
            end
            CMD_WRITE:
            begin
                if (ix < cx)
                    plan.do_write = 1'b1;
                else
                    plan.status = STAT_RANGE;
            end
            CMD_INSERT, CMD_PUSH_BACK, CMD_PUSH_FRONT:
            begin
                if (cmd.command == CMD_PUSH_BACK)
                    at_x = cx;
                else if (cmd.command == CMD_PUSH_FRONT)
                    at_x = '0;
                // range check wins over full
                if (at_x > cx)
                    plan.status = STAT_RANGE;
                else if (cx >= cap_x)
                    plan.status = STAT_FULL;
                else
                begin
                    plan.walk = WALK_INSERT;
                    start     = count;
                    stop      = CW'(at_x);
                    new_count = CW'(cx + XW'(1));
                end
            end
            CMD_ERASE:
            begin
                if (ix >= cx)
                    plan.status = STAT_RANGE;
                else if (lenc_x != '0)
                begin
                    plan.walk = WALK_ERASE;
                    start     = CW'(ix + lenc_x);
                    offset    = CW'(lenc_x);
                    new_count = CW'(cx - lenc_x);
                end
            end
            CMD_POP_BACK:
            begin
                if (cx == '0)
                    plan.status = STAT_RANGE;
                else
                    new_count = CW'(cx - XW'(1));
            end
            CMD_FIND:
            begin
                start = '0;
                if (cx != '0)
                    plan.walk = WALK_FIND;
            end
            CMD_CLEAR:
                new_count = '0;
            default:
                plan.walk = WALK_NONE;
        endcase
    end

endmodule

>>> design/ordered_array_table.sv
// channel | dir | handshake             | payload
// cmd     | in  | cmd_valid / cmd_stall | oat_in_t  (command, index, length, value)
// rsp     | out | rsp_valid / rsp_stall | oat_out_t (read_value, found, found_index,
//         |     |                       |            count, status)
// Insert moves the (count - index) entries at and above the index, erase moves the
// (count - index - clipped length) entries above the erased range, find reads up to
// count entries. The walk moves one entry per cycle through the single read and
// single write port of the entry memory; one command is in work at a time.
// Reset clears the count and the sequencer; the entry memory is not cleared.
// rsp is held in an output register; a new command is taken while it stalls.
module ordered_array_table #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  oat_pkg::oat_in_t  cmd,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output oat_pkg::oat_out_t rsp
);
    import oat_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = VALUE_WIDTH;

    oat_plan_t     plan;
    logic [CW-1:0] plan_count;
    logic [CW-1:0] plan_start;
    logic [CW-1:0] plan_stop;
    logic [CW-1:0] plan_offset;

    oat_state_t    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pend_reg, pend_next;
    logic          rsp_valid_reg, rsp_valid_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] stop_reg, stop_next;
    logic [CW-1:0] off_reg, off_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic [VW-1:0] val_reg, val_next;
    oat_out_t      res_reg, res_next;
    oat_out_t      rsp_reg, rsp_next;

    logic [VW-1:0] mem [CAPACITY];
    logic [VW-1:0] rdata_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [VW-1:0] wr_data;

    logic          accept;
    logic [VW+31:0] val_ext;
    logic [VW+31:0] rd_ext;
    logic [AW+5:0]  fidx_ext;
    logic [CW+6:0]  cnt_ext;
    logic [CW-1:0]  ptr_inc;
    logic [CW-1:0]  ptr_dec;
    logic [CW-1:0]  ptr_dst;

    oat_plan #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_plan (
        .cmd       (cmd),
        .count     (count_reg),
        .plan      (plan),
        .new_count (plan_count),
        .start     (plan_start),
        .stop      (plan_stop),
        .offset    (plan_offset)
    );

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign val_ext  = {{VW{1'b0}}, cmd.value};
    assign rd_ext   = {32'b0, rdata_reg};
    assign fidx_ext = {6'b0, pend_addr_reg};
    assign cnt_ext  = {7'b0, plan_count};
    assign ptr_inc  = ptr_reg + CW'(1);
    assign ptr_dec  = ptr_reg - CW'(1);
    assign ptr_dst  = ptr_reg - off_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pend_next      = pend_reg;
        ptr_next       = ptr_reg;
        stop_next      = stop_reg;
        off_next       = off_reg;
        pend_addr_next = pend_addr_reg;
        val_next       = val_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = pend_addr_reg;
        wr_data        = rdata_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next           = plan_count;
                    ptr_next             = plan_start;
                    stop_next            = plan_stop;
                    off_next             = plan_offset;
                    val_next             = val_ext[VW-1:0];
                    pend_next            = 1'b0;
                    res_next.read_value  = '0;
                    res_next.found       = 1'b0;
                    res_next.found_index = '0;
                    res_next.count       = cnt_ext[6:0];
                    res_next.status      = plan.status;
                    unique case (plan.walk)
                        WALK_READ:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = plan_start[AW-1:0];
                            state_next = ST_READ;
                        end
                        WALK_INSERT: state_next = ST_INSERT;
                        WALK_ERASE:  state_next = ST_ERASE;
                        WALK_FIND:   state_next = ST_FIND;
                        default:
                        begin
                            wr_en      = plan.do_write;
                            wr_addr    = plan_start[AW-1:0];
                            wr_data    = val_ext[VW-1:0];
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_next.read_value = signed'(rd_ext[31:0]);
                state_next          = ST_FINISH;
            end
            ST_INSERT:
            begin
                // move the tail up one place, top entry first
                wr_en = pend_reg;
                if (ptr_reg > stop_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = ptr_dec[AW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[AW-1:0];
                    ptr_next       = ptr_dec;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = stop_reg[AW-1:0];
                        wr_data    = val_reg;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_ERASE:
            begin
                // pull the tail down by the clipped length
                wr_en = pend_reg;
                if (ptr_reg < stop_reg)
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_dst[AW-1:0];
                    ptr_next       = ptr_inc;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                        state_next = ST_FINISH;
                end
            end
            ST_FIND:
            begin
                if (pend_reg && (rdata_reg == val_reg))
                begin
                    res_next.found       = 1'b1;
                    res_next.found_index = fidx_ext[5:0];
                    pend_next            = 1'b0;
                    state_next           = ST_FINISH;
                end
                else if (ptr_reg < stop_reg)
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[AW-1:0];
                    ptr_next       = ptr_inc;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                        state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold the result until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        stop_reg      <= stop_next;
        off_reg       <= off_next;
        pend_addr_reg <= pend_addr_next;
        val_reg       <= val_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rdata_reg <= mem[rd_addr];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

endmodule

>>> design/oat_checker.sv
module oat_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_stall,
    input oat_pkg::oat_in_t  cmd,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input oat_pkg::oat_out_t rsp
);
    import oat_pkg::*;

    // one command in work at a time
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("command taken while busy");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.found) |-> (rsp.status == STAT_OK && rsp.read_value == 0))
        else $error("find result carries read data or error status");

    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.read_value != 0) |-> (rsp.status == STAT_OK && !rsp.found))
        else $error("read data on a failed or non-read response");

endmodule

bind ordered_array_table oat_checker u_oat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

>>> tb/tb_ordered_array_table.sv
module tb_ordered_array_table;
    timeunit 1ns;
    timeprecision 1ps;

    import oat_pkg::*;

    localparam int          HALF_PERIOD      = 5;
    localparam int          TABLE_DEPTH      = 64;
    localparam int          RANDOM_ITEMS     = 740;
    localparam int          DRAIN_CYCLES     = 150;
    localparam int          CYCLE_LIMIT      = 1_000_000;
    localparam int          PRINT_LIMIT      = 40;
    localparam logic [3:0]  CMD_FIRST_UNUSED = 4'd9;
    localparam logic [3:0]  CMD_LAST_UNUSED  = 4'd15;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    oat_in_t  cmd       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    oat_out_t rsp;

    // predicted table contents and fill level
    logic [31:0] model_vals [TABLE_DEPTH];
    int unsigned model_count = 0;

    oat_out_t    rsp_due_q [$];
    oat_out_t    rsp_want;
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;
    int unsigned stall_left  = 0;
    int unsigned stall_mode  = 0;

    ordered_array_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ordered_array_table regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PRINT_LIMIT)
            $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic logic [1:0] table_place(input int unsigned at, input logic [31:0] v);
        int unsigned k;
        if (at > model_count)
            return STAT_RANGE;
        if (model_count >= TABLE_DEPTH)
            return STAT_FULL;
        for (k = model_count; k > at; k--)
            model_vals[k] = model_vals[k - 1];
        model_vals[at] = v;
        model_count++;
        return STAT_OK;
    endfunction

    function automatic oat_out_t table_apply(input oat_in_t item);
        oat_out_t    r;
        int unsigned k;
        int unsigned span;
        bit          hit;
        r   = '0;
        hit = 1'b0;
        case (item.command)
            CMD_READ:
                if (item.index < model_count)
                    r.read_value = model_vals[item.index];
                else
                    r.status = STAT_RANGE;
            CMD_WRITE:
                if (item.index < model_count)
                    model_vals[item.index] = item.value;
                else
                    r.status = STAT_RANGE;
            CMD_INSERT:     r.status = table_place(item.index, item.value);
            CMD_PUSH_BACK:  r.status = table_place(model_count, item.value);
            CMD_PUSH_FRONT: r.status = table_place(0, item.value);
            CMD_ERASE:
                if (item.index >= model_count)
                    r.status = STAT_RANGE;
                else
                begin
                    // clip the range at the end of the table
                    span = item.length;
                    if (span > model_count - item.index)
                        span = model_count - item.index;
                    for (k = item.index; k + span < model_count; k++)
                        model_vals[k] = model_vals[k + span];
                    model_count -= span;
                end
            CMD_POP_BACK:
                if (model_count == 0)
                    r.status = STAT_RANGE;
                else
                    model_count--;
            CMD_FIND:
                for (k = 0; k < model_count && !hit; k++)
                    if (model_vals[k] == item.value)
                    begin
                        hit           = 1'b1;
                        r.found       = 1'b1;
                        r.found_index = k[5:0];
                    end
            CMD_CLEAR:      model_count = 0;
            default:        ;
        endcase
        r.count = model_count[6:0];
        return r;
    endfunction

    // One transfer on cmd; keep valid high inside a burst, drop it for a gap after.
    task automatic send_cmd(input logic [3:0] c, input logic [6:0] i, input logic [6:0] l,
                            input logic [31:0] v);
        oat_in_t     item;
        int unsigned gap;
        item.command = c;
        item.index   = i;
        item.length  = l;
        item.value   = v;
        cmd       <= item;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        rsp_due_q.push_back(table_apply(item));
        if (burst_left == 0)
        begin
            cmd_valid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
        end
        else
            burst_left--;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rsp_due_q.size() == 0)
                report_mismatch("transfer with nothing expected", rsp.read_value, '0);
            else
            begin
                rsp_want = rsp_due_q.pop_front();
                if (rsp.read_value !== rsp_want.read_value)
                    report_mismatch("read_value", rsp.read_value, rsp_want.read_value);
                if (rsp.found !== rsp_want.found)
                    report_mismatch("found", rsp.found, rsp_want.found);
                if (rsp.found_index !== rsp_want.found_index)
                    report_mismatch("found_index", rsp.found_index, rsp_want.found_index);
                if (rsp.count !== rsp_want.count)
                    report_mismatch("count", rsp.count, rsp_want.count);
                if (rsp.status !== rsp_want.status)
                    report_mismatch("status", rsp.status, rsp_want.status);
            end
        end
    end

    // Receiver stalls in modes: open, light, heavy, and runs of four.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(3);
            stall_left = $urandom_range(20, 150);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(3) == 0);
            2:       rsp_stall <= ($urandom_range(3) != 0);
            default: rsp_stall <= stall_left[2];
        endcase
    end

    function automatic logic [31:0] pick_value();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 3)
            return $urandom_range(7);
        if (r == 3)
            case ($urandom_range(3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        return $urandom();
    endfunction

    function automatic logic [6:0] pick_index(input int unsigned span);
        int unsigned r;
        r = $urandom_range(19);
        if (r < 17)
            return 7'($urandom_range(span));
        if (r < 19)
            return 7'($urandom_range(127));
        return ($urandom_range(1) == 0) ? 7'd127 : 7'd64;
    endfunction

    function automatic logic [6:0] pick_length();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return 7'd0;
        if (r < 6)
            return 7'($urandom_range(1, 3));
        if (r < 8)
            return 7'($urandom_range(127));
        if (r == 8)
            return 7'd127;
        return 7'($urandom_range(64));
    endfunction

    task automatic test_empty_table();
        send_cmd(CMD_READ,       7'd0,   7'd0,   32'h0);
        send_cmd(CMD_WRITE,      7'd0,   7'd0,   32'hffff_ffff);
        send_cmd(CMD_ERASE,      7'd0,   7'd1,   32'h0);
        send_cmd(CMD_POP_BACK,   7'd127, 7'd127, 32'h0);
        send_cmd(CMD_FIND,       7'd0,   7'd0,   32'h0);
        send_cmd(CMD_INSERT,     7'd1,   7'd0,   32'h1);
        send_cmd(CMD_CLEAR,      7'd0,   7'd0,   32'h0);
        send_cmd(CMD_FIRST_UNUSED, 7'd127, 7'd127, 32'hffff_ffff);
        send_cmd(CMD_LAST_UNUSED,  7'd0,   7'd0,   32'h0);
    endtask

    task automatic test_basic_ops();
        send_cmd(CMD_PUSH_BACK,  7'd0, 7'd0, 32'h8000_0000);
        send_cmd(CMD_PUSH_BACK,  7'd0, 7'd0, 32'h7fff_ffff);
        send_cmd(CMD_PUSH_FRONT, 7'd0, 7'd0, 32'h0);
        send_cmd(CMD_PUSH_BACK,  7'd0, 7'd0, 32'hffff_ffff);
        send_cmd(CMD_INSERT,     7'd2, 7'd0, 32'd5);
        send_cmd(CMD_INSERT,     7'(model_count), 7'd0, 32'd5);
        send_cmd(CMD_READ,       7'd0, 7'd0, 32'h0);
        send_cmd(CMD_READ,       7'(model_count - 1), 7'd0, 32'h0);
        send_cmd(CMD_READ,       7'(model_count), 7'd0, 32'h0);
        send_cmd(CMD_READ,       7'd127, 7'd0, 32'h0);
        send_cmd(CMD_WRITE,      7'd1, 7'd0, 32'h1234_5678);
        // duplicate value: the first match wins
        send_cmd(CMD_FIND,       7'd0, 7'd0, 32'd5);
        send_cmd(CMD_FIND,       7'd0, 7'd0, 32'h0bad_f00d);
        send_cmd(CMD_ERASE,      7'd1, 7'd0, 32'h0);
        send_cmd(CMD_ERASE,      7'd1, 7'd1, 32'h0);
        send_cmd(CMD_ERASE,      7'd2, 7'd127, 32'h0);
        send_cmd(CMD_ERASE,      7'(model_count), 7'd1, 32'h0);
        send_cmd(CMD_POP_BACK,   7'd0, 7'd0, 32'h0);
        send_cmd(CMD_CLEAR,      7'd0, 7'd0, 32'h0);
    endtask

    task automatic test_full_table();
        while (model_count < TABLE_DEPTH)
            send_cmd(CMD_PUSH_BACK, 7'($urandom_range(127)), 7'($urandom_range(127)),
                     pick_value());
        send_cmd(CMD_PUSH_BACK,  7'd0,   7'd0, 32'h5a5a_5a5a);
        send_cmd(CMD_PUSH_FRONT, 7'd0,   7'd0, 32'h5a5a_5a5a);
        send_cmd(CMD_INSERT,     7'd10,  7'd0, 32'h5a5a_5a5a);
        send_cmd(CMD_INSERT,     7'd64,  7'd0, 32'h5a5a_5a5a);
        // range is checked before full
        send_cmd(CMD_INSERT,     7'd65,  7'd0, 32'h5a5a_5a5a);
        send_cmd(CMD_INSERT,     7'd127, 7'd0, 32'h5a5a_5a5a);
        send_cmd(CMD_READ,       7'd63,  7'd0, 32'h0);
        send_cmd(CMD_FIND,       7'd0,   7'd0, model_vals[TABLE_DEPTH - 1]);
        send_cmd(CMD_WRITE,      7'd63,  7'd0, 32'h7fff_ffff);
        send_cmd(CMD_READ,       7'd64,  7'd0, 32'h0);
        send_cmd(CMD_ERASE,      7'd0,   7'd64, 32'h0);
    endtask

    // Steer the fill level toward a moving target so empty, full and everything
    // between are all visited.
    task automatic test_random_mix(input int unsigned n_items);
        int unsigned done;
        int unsigned target;
        int unsigned r;
        logic [3:0]  c;
        logic [6:0]  i;
        logic [6:0]  l;
        logic [31:0] v;
        bit          grow;
        done   = 0;
        target = TABLE_DEPTH / 2;
        while (done < n_items)
        begin
            if (done % 60 == 0)
                case ($urandom_range(4))
                    0:       target = 0;
                    1:       target = TABLE_DEPTH;
                    2:       target = 1;
                    default: target = $urandom_range(TABLE_DEPTH);
                endcase
            i    = pick_index(model_count);
            l    = pick_length();
            v    = pick_value();
            grow = (model_count < target) ||
                   (model_count == target && $urandom_range(1) == 1);
            r    = $urandom_range(99);
            if (r < 10)
                c = CMD_READ;
            else if (r < 18)
                c = CMD_WRITE;
            else if (r < 28)
            begin
                c = CMD_FIND;
                if (model_count != 0 && $urandom_range(1) == 1)
                    v = model_vals[$urandom_range(model_count - 1)];
            end
            else if (r < 30)
                c = CMD_CLEAR;
            else if (r < 33)
                c = CMD_FIRST_UNUSED + 4'($urandom_range(CMD_LAST_UNUSED - CMD_FIRST_UNUSED));
            else if ($urandom_range(99) < (grow ? 80 : 20))
                case ($urandom_range(2))
                    0:       c = CMD_INSERT;
                    1:       c = CMD_PUSH_BACK;
                    default: c = CMD_PUSH_FRONT;
                endcase
            else
                c = ($urandom_range(2) == 0) ? CMD_POP_BACK : CMD_ERASE;
            send_cmd(c, i, l, v);
            if (c <= CMD_CLEAR)
                done++;
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_basic_ops();
        test_full_table();
        test_random_mix(RANDOM_ITEMS);
        cmd_valid <= 1'b0;
        while (rsp_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ordered_array_table regression: pass");
        else
            $display("ordered_array_table regression: fail");
        $finish;
    end

endmodule

>>> files.f
design/oat_pkg.sv
design/oat_plan.sv
design/ordered_array_table.sv
design/oat_checker.sv
tb/tb_ordered_array_table.sv
